// ===== design/thermistor_scan_to_temperature_macros.svh =====
// Assertion macros for the thermistor scan block.
// Used by the checker; depends on nothing.
`ifndef THERMISTOR_SCAN_TO_TEMPERATURE_MACROS_SVH
`define THERMISTOR_SCAN_TO_TEMPERATURE_MACROS_SVH
// implication property with report
`define TST_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication property with report
`define TST_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== design/tst_pkg.sv =====
// Package for the thermistor scan block: types, constants, log table.
// No dependencies.
package tst_pkg;
  localparam int unsigned AdcFull = 65472;
  localparam logic signed [15:0] TLow = -16'sd27315;
  localparam logic signed [15:0] THigh = 16'sd30000;
  localparam logic [15:0] Ln2Q16 = 16'd45426;

  // B*6553600/29815 = 219*B + 24115*B/29815; the last quotient uses a
  // reciprocal: floor(y/29815) = (y*CRecip) >> CDivK for any y below 2^29
  localparam logic [7:0]  CMulHi = 8'd219;
  localparam logic [14:0] CMulLo = 15'd24115;
  localparam logic [29:0] CRecip = 30'd590044812;
  localparam int          CDivK = 44;

  localparam logic [1:0] RegDivider = 2'd0;
  localparam logic [1:0] RegBeta = 2'd1;
  localparam logic [1:0] RegNominal = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DSTART, ST_DIV, ST_NORM, ST_LOG1, ST_LOG2, ST_CSUM,
    ST_TNUM, ST_TSTART, ST_TDIV, ST_DONE, ST_OUT
  } tst_state_t;

  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0: r = 16'd0;      5'd1: r = 16'd3973;   5'd2: r = 16'd7719;
      5'd3: r = 16'd11262;  5'd4: r = 16'd14624;  5'd5: r = 16'd17821;
      5'd6: r = 16'd20870;  5'd7: r = 16'd23783;  5'd8: r = 16'd26573;
      5'd9: r = 16'd29248;  5'd10: r = 16'd31818; 5'd11: r = 16'd34292;
      5'd12: r = 16'd36675; 5'd13: r = 16'd38975; 5'd14: r = 16'd41196;
      5'd15: r = 16'd43345; default: r = 16'd45426;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mux_map(input logic [1:0] c);
    logic [2:0] r;
    unique case (c)
      2'd0: r = 3'd4;
      2'd1: r = 3'd3;
      2'd2: r = 3'd2;
      default: r = 3'd5;
    endcase
    return r;
  endfunction
endpackage

// ===== design/tst_stream_if.sv =====
// Valid/ready channel interface with a parameterized payload type.
// Depends on nothing.
interface tst_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/tst_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit unsigned.
// Depends on nothing.
module tst_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] quo
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], q[63]} - {1'b0, den};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      q <= num;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule

// ===== design/thermistor_scan_to_temperature.sv =====
// Top level: thermistor reading to centidegrees with round-robin channel tag.
// Depends on tst_pkg, tst_stream_if, tst_divider.
//
//  channel  dir  payload                                  notes
//  in_ch    in   adc_sum[15:0]                            one transfer per item
//  out_ch   out  channel, temperature_centi, next_mux     one transfer per item
//  cfg      in   cfg_we, cfg_index[1:0], cfg_data[19:0]   write only
//
// Between the input transfer and out_ch.valid lie two passes of the one
// shared restoring divider (ratio, final quotient) and nine steps
// (multiplies, divider starts, normalize, log, B/298.15 by reciprocal).
// Bad input or a zero register skips both passes; log sum <= 0, the second.
// The result sits in an output register until taken; in_ch.ready is low from
// acceptance until the cycle after the result transfer.
// Reset is synchronous: config registers return to their defaults, channel to 0.
module thermistor_scan_to_temperature
  import tst_pkg::*;
#(
  parameter int NUM_SENSORS = 4
) (
  input  logic        clk,
  input  logic        rst,
  tst_stream_if.sink   in_ch,
  tst_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  localparam int CW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic [19:0] divider_ohms, nominal_ohms;
  logic [13:0] beta_kelvin;
  logic [CW-1:0] cur_ch, nxt_ch;
  tst_state_t state, state_next;

  logic [15:0] adc;
  logic [63:0] acc_a, acc_b;   // work registers
  logic [31:0] ratio;
  logic [4:0]  msb;
  logic signed [47:0] lnv;     // ln(x) Q16
  logic signed [47:0] s_val;
  logic signed [15:0] temp_res;
  logic [1:0]  out_chn;
  logic [2:0]  out_mux;
  logic [28:0] cy;             // 24115*B
  logic [21:0] cval;           // B/298.15 in Q16

  logic        div_start, div_busy;
  logic [63:0] div_num, div_den, div_quo;

  tst_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ohms <= 20'd4700;
      beta_kelvin <= 14'd4110;
      nominal_ohms <= 20'd10000;
    end else if (cfg_we) begin
      priority case (cfg_index)
        RegDivider: divider_ohms <= cfg_data;
        RegBeta: beta_kelvin <= cfg_data[13:0];
        RegNominal: nominal_ohms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(cur_ch) + 32'd1 >= 32'(NUM_SENSORS)) nxt_ch = '0;
    else nxt_ch = cur_ch + CW'(1);
  end

  // leading-one search on ratio (32 bits)
  logic [4:0] lz_pos;
  always_comb begin
    lz_pos = '0;
    for (int i = 0; i < 32; i++) if (ratio[i]) lz_pos = 5'(i);
  end

  logic [31:0] ynorm;
  logic [3:0]  idx;
  logic [26:0] remf;
  logic [15:0] t0, t1;
  assign ynorm = ratio << (5'd31 - msb);
  assign idx = ynorm[30:27];
  assign remf = ynorm[26:0];
  assign t0 = ln_tab({1'b0, idx});
  assign t1 = ln_tab({1'b0, idx} + 5'd1);

  logic [43:0] interp_prod;
  assign interp_prod = 44'(t1 - t0) * 44'(remf);

  // floor(24115*B/29815) by reciprocal multiply, exact for 24115*B < 2^29
  logic [58:0] cq_prod;
  assign cq_prod = 59'(cy) * 59'(CRecip);

  logic bad_in;
  assign bad_in = (adc == 16'd0) || (32'(adc) >= AdcFull) || divider_ohms == '0
                  || beta_kelvin == '0 || nominal_ohms == '0;

  logic signed [47:0] bnum;   // B*6553600
  assign bnum = 48'(beta_kelvin) * 48'd6553600;

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_num = acc_a;
    div_den = acc_b;
    in_ch.ready = (state == ST_IDLE);
    out_ch.valid = (state == ST_OUT);
    unique case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_MUL;
      ST_MUL: begin
        if (bad_in) state_next = ST_DONE;
        else state_next = ST_DSTART;
      end
      // operands were loaded on the previous edge
      ST_DSTART: begin
        div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: if (!div_busy) state_next = ST_NORM;
      ST_NORM: state_next = ST_LOG1;
      ST_LOG1: state_next = ST_LOG2;
      ST_LOG2: state_next = ST_CSUM;
      ST_CSUM: state_next = ST_TNUM;
      ST_TNUM: begin
        if (s_val <= 0) state_next = ST_DONE;
        else state_next = ST_TSTART;
      end
      ST_TSTART: begin
        div_start = 1'b1;
        state_next = ST_TDIV;
      end
      ST_TDIV: if (!div_busy) state_next = ST_DONE;
      ST_DONE: state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic neg_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ch <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          adc <= in_ch.data;
          out_chn <= 2'(cur_ch);
          out_mux <= mux_map(2'(nxt_ch));
          cur_ch <= nxt_ch;
          temp_res <= TLow;
        end
        ST_MUL: begin
          acc_a <= {12'd0, 36'(divider_ohms) * 36'(adc), 16'd0};
          acc_b <= 64'(36'(16'(AdcFull) - adc) * 36'(nominal_ohms));
        end
        ST_DIV: if (!div_busy) ratio <= (div_quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
            : ((div_quo == 64'd0) ? 32'd1 : div_quo[31:0]);
        ST_NORM: msb <= lz_pos;
        ST_LOG1: begin
          lnv <= 48'(signed'({1'b0, msb}) - 6'sd16) * 48'(Ln2Q16)
                 + 48'(t0) + 48'(interp_prod[43:27]);
          cy <= 29'(beta_kelvin) * 29'(CMulLo);
        end
        ST_LOG2: cval <= 22'(beta_kelvin) * 22'(CMulHi) + 22'(cq_prod[58:CDivK]);
        ST_CSUM: s_val <= lnv + 48'(cval);
        ST_TNUM: begin
          if (s_val < 0) temp_res <= TLow;
          else if (s_val == 0) temp_res <= THigh;
          // numerator may be negative: divide magnitudes
          neg_flag <= (bnum < 48'sd27315 * s_val);
          acc_a <= (bnum >= 48'sd27315 * s_val) ? 64'(bnum - 48'sd27315 * s_val)
                   : 64'(48'sd27315 * s_val - bnum);
          acc_b <= 64'(s_val);
        end
        ST_TDIV: if (!div_busy) begin
          if (!neg_flag && div_quo > 64'd30000) temp_res <= THigh;
          else if (neg_flag && div_quo > 64'd27315) temp_res <= TLow;
          else if (neg_flag) temp_res <= -16'(signed'(div_quo[15:0]));
          else temp_res <= 16'(div_quo[15:0]);
        end
        default: ;
      endcase
    end
  end

  assign out_ch.data.channel = out_chn;
  assign out_ch.data.temperature_centi = temp_res;
  assign out_ch.data.next_mux_input = out_mux;
endmodule

// ===== design/tst_checker.sv =====
// Port-level checker for the thermistor scan block, bound to the top level.
// Depends on tst_pkg and the macros header.
`include "thermistor_scan_to_temperature_macros.svh"
module tst_checker
  import tst_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [15:0] temp,
  input logic [2:0]  nmux
);
  `TST_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready, "ready while result pending")
  `TST_ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "ready after transfer")
  `TST_ASSERT_IMP(a_rng, clk, rst, out_valid, temp >= TLow && temp <= THigh, "temp range")
  `TST_ASSERT_IMP(a_mux, clk, rst, out_valid, nmux >= 3'd2 && nmux <= 3'd5, "mux range")
endmodule

bind thermistor_scan_to_temperature tst_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .temp(out_ch.data.temperature_centi), .nmux(out_ch.data.next_mux_input)
);

// ===== test/tb_top.sv =====
// Self-checking bench for thermistor_scan_to_temperature: ADC sums in, tagged temperatures out.
// Depends on tst_pkg, tst_stream_if and the block's RTL.
module tb_top;
  import tst_pkg::*;

  typedef struct packed {
    logic [1:0]         channel;
    logic signed [15:0] temperature_centi;
    logic [2:0]         next_mux_input;
  } temp_result_t;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 300;

  // ln(1+i/16) in Q16, 17 knots for the interpolated log
  localparam int LOG_KNOTS [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
    26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
  localparam logic [2:0] NEXT_INPUT [4] = '{3'd4, 3'd3, 3'd2, 3'd5};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = RegDivider;
  logic [19:0] cfg_data = '0;

  tst_stream_if #(.payload_t(logic [15:0])) adc_if ();
  tst_stream_if #(.payload_t(temp_result_t)) temp_if ();

  thermistor_scan_to_temperature i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (adc_if),
    .out_ch    (temp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bench copy of the block's registers and channel counter
  logic [19:0] divider_q = 20'd4700;
  logic [13:0] beta_q = 14'd4110;
  logic [19:0] nominal_q = 20'd10000;
  logic [1:0]  scan_channel = 2'd0;

  logic [15:0]  adc_pending [$];
  temp_result_t temps_due [$];
  int max_gap = 8;     // per-phase idling bound for both sides
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;

  // Natural log of a nonzero Q16.16 value, Q16.16 signed result.
  function automatic longint log_q16(input logic [31:0] x);
    int msb;
    logic [31:0] y;
    logic [3:0] seg;
    logic [26:0] frac;
    longint step;
    msb = 0;
    for (int i = 0; i < 32; i++) if (x[i]) msb = i;
    y = x << (31 - msb);
    seg = y[30:27];
    frac = y[26:0];
    step = LOG_KNOTS[seg + 1] - LOG_KNOTS[seg];
    return longint'(msb - 16) * 45426 + LOG_KNOTS[seg] + ((step * frac) >>> 27);
  endfunction

  // Beta equation in fixed point, result in centidegrees C.
  function automatic logic signed [15:0] centi_from_adc(input logic [15:0] adc);
    longint unsigned num, den, ratio;
    longint b, c, s, t;
    if (adc == 0 || adc >= 16'd65472) return -16'sd27315;
    if (divider_q == 0 || beta_q == 0 || nominal_q == 0) return -16'sd27315;
    num = (longint'(divider_q) * adc) << 16;
    den = longint'(65472 - adc) * nominal_q;
    ratio = num / den;
    if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
    if (ratio == 0) ratio = 1;
    b = beta_q;
    c = (b * 6553600) / 29815;
    s = log_q16(ratio[31:0]) + c;
    if (s < 0) return -16'sd27315;      // nonphysical
    if (s == 0) return 16'sd30000;      // infinite temperature
    t = (b * 6553600 - 64'sd27315 * s) / s;   // truncates toward zero
    if (t > 30000) t = 30000;
    if (t < -27315) t = -27315;
    return t[15:0];
  endfunction

  // Driver: one transfer per item, random hold-off before each new item.
  int adc_gap = 0;
  always @(posedge clk) begin
    logic nv;
    temp_result_t r;
    nv = adc_if.valid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (adc_if.valid && adc_if.ready) begin
        r.channel = scan_channel;
        r.temperature_centi = centi_from_adc(adc_if.data);
        r.next_mux_input = NEXT_INPUT[scan_channel + 2'd1];
        temps_due.push_back(r);
        scan_channel <= scan_channel + 2'd1;
        n_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (adc_gap != 0) begin
          adc_gap <= adc_gap - 1;
        end else if (adc_pending.size() != 0) begin
          adc_if.data <= adc_pending.pop_front();
          nv = 1'b1;
          adc_gap <= $urandom_range(max_gap, 0);
        end
      end
    end
    adc_if.valid <= nv;
  end

  // Monitor: random backpressure, compare every transfer with the oldest prediction.
  int temp_stall = 0;
  always @(posedge clk) begin
    temp_result_t exp_r;
    if (rst) begin
      temp_if.ready <= 1'b0;
    end else if (temp_if.valid && temp_if.ready) begin
      if (temps_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, temp_if.data);
        errors++;
      end else begin
        exp_r = temps_due.pop_front();
        n_checked++;
        if (temp_if.data.channel !== exp_r.channel) begin
          $display("%0t: channel exp %0d got %0d", $time, exp_r.channel,
                   temp_if.data.channel);
          errors++;
        end
        if (temp_if.data.temperature_centi !== exp_r.temperature_centi) begin
          $display("%0t: temperature exp %0d got %0d", $time, exp_r.temperature_centi,
                   temp_if.data.temperature_centi);
          errors++;
        end
        if (temp_if.data.next_mux_input !== exp_r.next_mux_input) begin
          $display("%0t: next_mux_input exp %0d got %0d", $time, exp_r.next_mux_input,
                   temp_if.data.next_mux_input);
          errors++;
        end
      end
      temp_stall = $urandom_range(max_gap, 0);
      temp_if.ready <= (temp_stall == 0);
    end else if (temp_stall > 0) begin
      temp_stall--;
      temp_if.ready <= (temp_stall == 0);
    end else begin
      temp_if.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (adc_if.valid && adc_if.ready) || (temp_if.valid && temp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, temps_due.size());
      $display("[thermistor_scan_to_temperature] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == RegDivider) divider_q = val;
    else if (idx == RegBeta) beta_q = val[13:0];
    else if (idx == RegNominal) nominal_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [19:0] dv, input logic [19:0] bv,
                           input logic [19:0] nv);
    write_reg(RegDivider, dv);
    write_reg(RegBeta, bv);
    write_reg(RegNominal, nv);
  endtask

  // Block is idle once every item is transferred and every result taken.
  // Sampled on the falling edge, after all clocked updates have settled.
  task automatic drain();
    do
      @(negedge clk);
    while (adc_pending.size() != 0 || adc_if.valid || temps_due.size() != 0);
  endtask

  function automatic logic [15:0] random_adc();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 80) return 16'($urandom_range(65471, 1));
    if (pick < 88) return 16'($urandom_range(300, 0));
    if (pick < 96) return 16'($urandom_range(65472, 65100));
    return 16'($urandom_range(65535, 65473));   // past full scale
  endfunction

  initial begin
    adc_if.valid = 1'b0;
    adc_if.data = '0;
    temp_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, reading extremes and full-scale edges.
    adc_pending = '{16'd0, 16'd1, 16'd2, 16'd65471, 16'd65472, 16'd65473, 16'd65535,
                    16'd32736, 16'h5555, 16'hAAAA, 16'd21824, 16'd43648, 16'd100,
                    16'd65000, 16'h00FF, 16'hFF00};
    drain();

    // Extremes: tiny ratio with low beta drives the log sum negative.
    write_all(20'd1, 20'd1000, 20'd1000000);
    adc_pending = '{16'd1, 16'd2, 16'd100, 16'd32736, 16'd65471};
    drain();
    write_all(20'd1000000, 20'd10000, 20'd100);
    adc_pending = '{16'd1, 16'd32736, 16'd65000, 16'd65471};
    drain();
    // Zero registers, one at a time.
    write_all(20'd0, 20'd4110, 20'd10000);
    adc_pending = '{16'd32736};
    drain();
    write_all(20'd4700, 20'd0, 20'd10000);
    adc_pending = '{16'd32736};
    drain();
    write_all(20'd4700, 20'd4110, 20'd0);
    adc_pending = '{16'd32736};
    drain();

    // Random phases: register settings vary, some phases with no idling at all.
    for (int ph = 0; ph < 18; ph++) begin
      case (ph % 6)
        0: write_all(20'd4700, 20'd4110, 20'd10000);
        1: write_all(20'd1, 20'd1000, 20'd1000000);
        2: write_all(20'd1000000, 20'd10000, 20'd100);
        3: write_all(20'($urandom_range(1000000, 1)), 20'($urandom_range(10000, 1000)),
                     20'($urandom_range(1000000, 100)));
        4: write_all(20'($urandom_range(1000, 1)), 20'($urandom_range(16383, 1)),
                     20'($urandom_range(1000000, 100000)));
        default: write_all(20'($urandom), 20'($urandom), 20'($urandom));  // full 20-bit
      endcase
      max_gap = (ph % 4 == 1) ? 0 : 8;
      for (int k = 0; k < 50; k++) adc_pending.push_back(random_adc());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d ADC sums over 24 register settings, checked %0d temperatures.",
             n_sent, n_checked);
    if (errors == 0 && temps_due.size() == 0) begin
      $display("[thermistor_scan_to_temperature] OK");
    end else begin
      $display("[thermistor_scan_to_temperature] ERROR");
    end
    $finish;
  end
endmodule
